@@ hdl/ssmt_pkg.sv @@
// shared types and constants of the sorted sparse matrix table
package ssmt_pkg;

   // field widths of a request and of a table entry
   localparam int KEY_W  = 20;
   localparam int VAL_W  = 32;
   localparam int DIM_W  = 10;
   localparam int LIM_W  = 11;
   localparam int NZ_W   = 7;

   // fixed matrix dimension bound, rows and columns at or above are rejected
   localparam logic [LIM_W-1:0] DIM_LIMIT = 11'd1024;

   // reset value of both limit registers
   localparam logic [LIM_W-1:0] LIMIT_RESET = 11'd1024;

   // action codes; the unused code reads
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_ACCUM = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // configuration register indexes
   localparam logic CSR_ROW_LIMIT    = 1'b0;
   localparam logic CSR_COLUMN_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_SAT   = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]              action;
      logic [DIM_W-1:0]        row;
      logic [DIM_W-1:0]        column;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] element_value;
      status_type              status;
      logic [NZ_W-1:0]         nonzero_count;
   } rsp_type;

   // outputs of the shared compare and accumulate unit
   typedef struct packed {
      logic                    key_ge;
      logic                    key_eq;
      logic signed [VAL_W-1:0] target;
      logic                    saturated;
   } alu_res_type;

endpackage

@@ hdl/ssmt_ram.sv @@
// generic single write, single read memory with registered read data
module ssmt_ram #(
   parameter int WIDTH = 52,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, old data on a same-address collision
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/ssmt_alu.sv @@
// shared key compare and saturating accumulate unit
module ssmt_alu (
   input  logic [ssmt_pkg::KEY_W-1:0]        entry_key,
   input  logic [ssmt_pkg::KEY_W-1:0]        req_key,
   input  logic [1:0]                        action,
   input  logic signed [ssmt_pkg::VAL_W-1:0] old_value,
   input  logic signed [ssmt_pkg::VAL_W-1:0] operand,
   output ssmt_pkg::alu_res_type             res
);

   localparam int VW = ssmt_pkg::VAL_W;

   logic signed [VW:0]   sum;
   logic signed [VW-1:0] sat_sum;
   logic                 ovf;

   // exact sum one bit wider, clamp on overflow
   assign sum = {old_value[VW-1], old_value} + {operand[VW-1], operand};
   assign ovf = sum[VW] != sum[VW-1];

   always_comb begin
      if (!ovf) begin
         sat_sum = sum[VW-1:0];
      end else if (sum[VW]) begin
         sat_sum = {1'b1, {(VW-1){1'b0}}};
      end else begin
         sat_sum = {1'b0, {(VW-1){1'b1}}};
      end
   end

   // key compare and the value the position should hold after the action
   always_comb begin
      // row-major order is plain order of the packed row and column key
      res.key_ge = entry_key >= req_key;
      res.key_eq = entry_key == req_key;
      unique case (action)
         ssmt_pkg::ACT_WRITE: begin
            res.target    = operand;
            res.saturated = 1'b0;
         end
         ssmt_pkg::ACT_ACCUM: begin
            res.target    = sat_sum;
            res.saturated = ovf;
         end
         default: begin
            res.target    = old_value;
            res.saturated = 1'b0;
         end
      endcase
   end

endmodule

@@ hdl/sorted_sparse_matrix_table.sv @@
// sorted sparse matrix table: top level with sequencer, entry memory and limits
//
// A request is taken when start is high and busy is low; its response is on
// rsp_data for exactly one cycle with rsp_valid high, in the first cycle that
// busy is low again, and cannot be held off. An out-of-range request answers
// in the next cycle without going busy. Otherwise the sorted entry memory is
// walked one entry per cycle from the start until the first key not below the
// requested one, then a decision step settles the response. A delete moves
// each entry behind the removed one down one place; an insert moves each entry
// behind the new slot up one place and then places the new entry, and moves
// none when the new entry goes to the end. A longer walk leaves fewer entries
// to move. Entries are walked and moved one at a time through the single read
// and single write port of the entry memory. Configuration writes take effect
// at once and are meant for idle times only.
module sorted_sparse_matrix_table #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  ssmt_pkg::req_type                req_data,
   output logic                             rsp_valid,
   output ssmt_pkg::rsp_type                rsp_data,
   input  logic                             csr_write,
   input  logic                             csr_index,
   input  logic [ssmt_pkg::LIM_W-1:0]       csr_wdata
);

   localparam int AW    = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int KW    = ssmt_pkg::KEY_W;
   localparam int VW    = ssmt_pkg::VAL_W;
   localparam int EW    = KW + VW;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_SCAN     = 6'b000010,
      S_DECIDE   = 6'b000100,
      S_SHIFT_DN = 6'b001000,
      S_SHIFT_UP = 6'b010000,
      S_PLACE    = 6'b100000
   } state_type;

   // count to response field, truncated or zero-extended
   function automatic logic [ssmt_pkg::NZ_W-1:0] cnt_field(input logic [CNT_W-1:0] c);
      logic [CNT_W+ssmt_pkg::NZ_W-1:0] w;
      w = {{ssmt_pkg::NZ_W{1'b0}}, c};
      return w[ssmt_pkg::NZ_W-1:0];
   endfunction

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           total_ff, total_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ssmt_pkg::LIM_W-1:0] row_limit_ff, col_limit_ff;

   logic [1:0]                 act_ff, act_in;
   logic [KW-1:0]              key_ff, key_in;
   logic signed [VW-1:0]       opnd_ff, opnd_in;
   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic [AW-1:0]              wptr_ff, wptr_in;
   logic signed [VW-1:0]       old_ff, old_in;
   logic                       found_ff, found_in;
   ssmt_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   logic                       ram_wr_en;
   logic [AW-1:0]              ram_wr_addr;
   logic [EW-1:0]              ram_wr_data;
   logic [AW-1:0]              ram_rd_addr;
   logic [EW-1:0]              ram_rd_data;

   ssmt_pkg::alu_res_type      alu;
   logic [CNT_W-1:0]           idx_next;
   logic [CNT_W-1:0]           total_dec;
   logic [CNT_W-1:0]           total_inc;
   logic [CNT_W-1:0]           wptr_wide;
   logic [AW-1:0]              wptr_up2;
   logic [AW-1:0]              wptr_dn2;
   logic                       range_bad;
   logic                       is_write;
   logic                       tgt_zero;
   ssmt_pkg::status_type       upd_status;

   // entry memory: key over value
   ssmt_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // shared compare and accumulate unit
   ssmt_alu u_alu (
      .entry_key (ram_rd_data[EW-1:VW]),
      .req_key   (key_ff),
      .action    (act_ff),
      .old_value (old_ff),
      .operand   (opnd_ff),
      .res       (alu)
   );

   // helper arithmetic on pointers and counts
   assign idx_next   = idx_ff + 1'b1;
   assign total_dec  = total_ff - 1'b1;
   assign total_inc  = total_ff + 1'b1;
   assign wptr_wide  = CNT_W'(wptr_ff);
   assign wptr_up2   = wptr_ff + AW'(2);
   assign wptr_dn2   = wptr_ff - AW'(2);
   assign is_write   = (act_ff == ssmt_pkg::ACT_WRITE) || (act_ff == ssmt_pkg::ACT_ACCUM);
   assign tgt_zero   = alu.target == '0;
   assign upd_status = alu.saturated ? ssmt_pkg::ST_SAT : ssmt_pkg::ST_OK;

   // range check of the incoming request
   assign range_bad = ({1'b0, req_data.row} >= row_limit_ff) ||
                      ({1'b0, req_data.column} >= col_limit_ff) ||
                      ({1'b0, req_data.row} >= ssmt_pkg::DIM_LIMIT) ||
                      ({1'b0, req_data.column} >= ssmt_pkg::DIM_LIMIT);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      act_in       = act_ff;
      key_in       = key_ff;
      opnd_in      = opnd_ff;
      idx_in       = idx_ff;
      wptr_in      = wptr_ff;
      old_in       = old_ff;
      found_in     = found_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wptr_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_addr  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in  = req_data.action;
               key_in  = {req_data.row, req_data.column};
               opnd_in = req_data.value;
               idx_in  = '0;
               if (range_bad) begin
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.element_value = '0;
                  rsp_data_in.status        = ssmt_pkg::ST_RANGE;
                  rsp_data_in.nonzero_count = cnt_field(total_ff);
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         // walk the sorted keys, one entry per cycle
         S_SCAN: begin
            ram_rd_addr = idx_next[AW-1:0];
            if (idx_ff == total_ff) begin
               found_in = 1'b0;
               old_in   = '0;
               state_in = S_DECIDE;
            end else if (alu.key_ge) begin
               found_in = alu.key_eq;
               old_in   = alu.key_eq ? ram_rd_data[VW-1:0] : '0;
               state_in = S_DECIDE;
            end else begin
               idx_in = idx_next;
            end
         end

         // settle the new value and what the table must do
         S_DECIDE: begin
            rsp_data_in.element_value = '0;
            rsp_data_in.status        = ssmt_pkg::ST_OK;
            rsp_data_in.nonzero_count = cnt_field(total_ff);
            rsp_valid_in              = 1'b1;
            state_in                  = S_IDLE;
            if (!is_write) begin
               rsp_data_in.element_value = old_ff;
            end else if (found_ff) begin
               if (tgt_zero) begin
                  // delete: close the gap behind the entry
                  total_in                  = total_dec;
                  rsp_data_in.nonzero_count = cnt_field(total_dec);
                  if (idx_next < total_ff) begin
                     wptr_in      = idx_ff[AW-1:0];
                     ram_rd_addr  = idx_next[AW-1:0];
                     rsp_valid_in = 1'b0;
                     state_in     = S_SHIFT_DN;
                  end
               end else begin
                  // update in place
                  ram_wr_en                 = 1'b1;
                  ram_wr_addr               = idx_ff[AW-1:0];
                  ram_wr_data               = {key_ff, alu.target};
                  rsp_data_in.element_value = alu.target;
                  rsp_data_in.status        = upd_status;
               end
            end else if (!tgt_zero) begin
               if (total_ff == MAX_CNT) begin
                  rsp_data_in.status = ssmt_pkg::ST_FULL;
               end else begin
                  // insert: open a slot unless it is at the end
                  total_in                  = total_inc;
                  rsp_data_in.nonzero_count = cnt_field(total_inc);
                  rsp_data_in.element_value = alu.target;
                  rsp_data_in.status        = upd_status;
                  if (idx_ff == total_ff) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = idx_ff[AW-1:0];
                     ram_wr_data = {key_ff, alu.target};
                  end else begin
                     wptr_in      = total_ff[AW-1:0];
                     ram_rd_addr  = total_dec[AW-1:0];
                     rsp_valid_in = 1'b0;
                     state_in     = S_SHIFT_UP;
                  end
               end
            end
         end

         // move entries one place down after a delete
         S_SHIFT_DN: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = wptr_ff;
            ram_rd_addr = wptr_up2;
            wptr_in     = wptr_ff + 1'b1;
            if (wptr_wide == total_dec) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         // move entries one place up ahead of an insert
         S_SHIFT_UP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = wptr_ff;
            ram_rd_addr = wptr_dn2;
            wptr_in     = wptr_ff - 1'b1;
            if (wptr_wide == idx_next) begin
               state_in = S_PLACE;
            end
         end

         // store the new entry in the opened slot
         S_PLACE: begin
            ram_wr_en    = 1'b1;
            ram_wr_addr  = idx_ff[AW-1:0];
            ram_wr_data  = {key_ff, rsp_data_ff.element_value};
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_limit_ff <= ssmt_pkg::LIMIT_RESET;
         col_limit_ff <= ssmt_pkg::LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            ssmt_pkg::CSR_ROW_LIMIT:    row_limit_ff <= csr_wdata;
            ssmt_pkg::CSR_COLUMN_LIMIT: col_limit_ff <= csr_wdata;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      key_ff      <= key_in;
      opnd_ff     <= opnd_in;
      idx_ff      <= idx_in;
      wptr_ff     <= wptr_in;
      old_ff      <= old_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // entry count stays within the table
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= MAX_CNT)
      else $error("entry count above table size");

   // the scan never passes the stored entries
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (idx_ff <= total_ff))
      else $error("scan index past entry count");

   // finishing an operation always delivers its response
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("operation ended without response");

   // a refused insert only happens on a full table
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ssmt_pkg::ST_FULL) |-> (total_ff == MAX_CNT))
      else $error("table full reported with free entries");

   // the table is only written while an operation runs
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> busy)
      else $error("entry memory written while idle");

endmodule

@@ test/sorted_sparse_matrix_table_tb.sv @@
// self-checking testbench of the sorted sparse matrix table
module sorted_sparse_matrix_table_tb;

   localparam int KEY_W = ssmt_pkg::KEY_W;
   localparam int VAL_W = ssmt_pkg::VAL_W;
   localparam int DIM_W = ssmt_pkg::DIM_W;
   localparam int LIM_W = ssmt_pkg::LIM_W;
   localparam int NZ_W  = ssmt_pkg::NZ_W;

   localparam int TABLE_DEPTH = 64;
   // longest walk plus shift through a full table
   localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 8;
   // unused action code, handled as a read
   localparam logic [1:0] ACT_SPARE = 2'd3;
   localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] Q_ONE = 32'sh0001_0000;
   localparam int PHASES = 5;

   typedef struct {
      ssmt_pkg::req_type request;
      bit                typed;
      ssmt_pkg::rsp_type response;
   } probe_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   ssmt_pkg::req_type   req_data;
   logic                rsp_valid;
   ssmt_pkg::rsp_type   rsp_data;
   logic                csr_write;
   logic                csr_index;
   logic [LIM_W-1:0]    csr_wdata;

   // shadow of the entry table and the limit registers
   logic [KEY_W-1:0]        stored_keys[TABLE_DEPTH];
   logic signed [VAL_W-1:0] stored_values[TABLE_DEPTH];
   int                      stored_total;
   logic [LIM_W-1:0]        row_bound;
   logic [LIM_W-1:0]        column_bound;

   ssmt_pkg::rsp_type awaited_elements[$];
   probe_row_type     directed_rows[$];
   int                mismatch_count;
   int                pool_row;
   int                pool_column;

   // per phase: row limit, column limit, sender idle percent, request count
   int phase_rows[PHASES]    = '{1024, 1, 9, 1024, 300};
   int phase_columns[PHASES] = '{1024, 1, 1024, 6, 513};
   int phase_idle[PHASES]    = '{10, 50, 50, 0, 0};
   int phase_items[PHASES]   = '{250, 100, 150, 100, 150};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   sorted_sparse_matrix_table #(
      .MAX_ENTRIES(TABLE_DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // first slot whose key is not below the given one
   function automatic int find_slot(logic [KEY_W-1:0] key);
      int slot;
      slot = 0;
      while (slot < stored_total && stored_keys[slot] < key) slot++;
      return slot;
   endfunction

   // value held at a position, zero when absent
   function automatic logic signed [VAL_W-1:0] value_at(logic [DIM_W-1:0] row,
                                                       logic [DIM_W-1:0] column);
      int slot;
      slot = find_slot({row, column});
      if (slot < stored_total && stored_keys[slot] == {row, column}) return stored_values[slot];
      return '0;
   endfunction

   // apply one request to the shadow table and return the expected response
   function automatic ssmt_pkg::rsp_type update_matrix(ssmt_pkg::req_type r);
      int slot;
      int k;
      bit hit;
      longint total;
      logic [KEY_W-1:0] key;
      logic signed [VAL_W-1:0] target;
      ssmt_pkg::rsp_type o;
      o.element_value = '0;
      o.status = ssmt_pkg::ST_OK;
      if ({1'b0, r.row} >= row_bound || {1'b0, r.column} >= column_bound ||
          {1'b0, r.row} >= ssmt_pkg::DIM_LIMIT ||
          {1'b0, r.column} >= ssmt_pkg::DIM_LIMIT) begin
         o.status = ssmt_pkg::ST_RANGE;
      end else begin
         key = {r.row, r.column};
         slot = find_slot(key);
         hit = (slot < stored_total) && (stored_keys[slot] == key);
         target = hit ? stored_values[slot] : '0;
         if (r.action == ssmt_pkg::ACT_WRITE) begin
            target = r.value;
         end else if (r.action == ssmt_pkg::ACT_ACCUM) begin
            total = longint'(target) + longint'(r.value);
            if (total > longint'(Q_MAX)) begin
               target = Q_MAX;
               o.status = ssmt_pkg::ST_SAT;
            end else if (total < longint'(Q_MIN)) begin
               target = Q_MIN;
               o.status = ssmt_pkg::ST_SAT;
            end else begin
               target = total[VAL_W-1:0];
            end
         end
         if (r.action == ssmt_pkg::ACT_WRITE || r.action == ssmt_pkg::ACT_ACCUM) begin
            if (hit) begin
               // update in place, or delete and close the gap
               if (target == 0) begin
                  for (k = slot; k < stored_total - 1; k++) begin
                     stored_keys[k] = stored_keys[k+1];
                     stored_values[k] = stored_values[k+1];
                  end
                  stored_total--;
               end else begin
                  stored_values[slot] = target;
               end
               o.element_value = target;
            end else if (target != 0) begin
               // insert a new entry unless the table is full
               if (stored_total >= TABLE_DEPTH) begin
                  o.status = ssmt_pkg::ST_FULL;
               end else begin
                  for (k = stored_total; k > slot; k--) begin
                     stored_keys[k] = stored_keys[k-1];
                     stored_values[k] = stored_values[k-1];
                  end
                  stored_keys[slot] = key;
                  stored_values[slot] = target;
                  stored_total++;
                  o.element_value = target;
               end
            end
         end else begin
            o.element_value = target;
         end
      end
      o.nonzero_count = NZ_W'(stored_total);
      return o;
   endfunction

   // random request, mostly on a small patch of the matrix so the table fills
   function automatic ssmt_pkg::req_type random_request();
      ssmt_pkg::req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      r.action = (pick < 40) ? ssmt_pkg::ACT_WRITE : (pick < 72) ? ssmt_pkg::ACT_ACCUM :
                 (pick < 95) ? ssmt_pkg::ACT_READ : ACT_SPARE;
      if ($urandom_range(0, 99) < 85) r.row = DIM_W'(pool_row + $urandom_range(0, 8));
      else r.row = DIM_W'($urandom_range(0, 1023));
      if ($urandom_range(0, 99) < 85) r.column = DIM_W'(pool_column + $urandom_range(0, 7));
      else r.column = DIM_W'($urandom_range(0, 1023));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         r.value = '0;
      end else if (pick < 20) begin
         case ($urandom_range(0, 3))
            0: r.value = Q_MAX;
            1: r.value = Q_MIN;
            2: r.value = Q_ONE;
            default: r.value = -1;
         endcase
      end else if (pick < 35 && r.action == ssmt_pkg::ACT_ACCUM) begin
         // cancel the stored value so the entry is deleted
         r.value = -value_at(r.row, r.column);
      end else begin
         r.value = $urandom;
      end
      return r;
   endfunction

   task automatic add_probe(logic [1:0] action, int row, int column,
                            logic signed [VAL_W-1:0] value, bit typed,
                            logic signed [VAL_W-1:0] want_value,
                            ssmt_pkg::status_type want_status, int want_count);
      probe_row_type p;
      p.request.action = action;
      p.request.row = DIM_W'(row);
      p.request.column = DIM_W'(column);
      p.request.value = value;
      p.typed = typed;
      p.response.element_value = want_value;
      p.response.status = want_status;
      p.response.nonzero_count = NZ_W'(want_count);
      directed_rows.push_back(p);
   endtask

   // drive one request and hold it until the block takes it
   task automatic issue_request(ssmt_pkg::req_type r, bit typed,
                                ssmt_pkg::rsp_type typed_rsp);
      ssmt_pkg::rsp_type predicted;
      @(negedge clock);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = update_matrix(r);
      awaited_elements.push_back(typed ? typed_rsp : predicted);
   endtask

   // sender gap of random length, long enough to reach past a busy stretch
   task automatic sender_gap(int percent);
      if ($urandom_range(0, 99) < percent) begin
         repeat ($urandom_range(1, SETTLE_CYCLES)) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
   endtask

   // stop requesting and wait for every awaited response
   task automatic drain_responses();
      @(negedge clock);
      start <= 1'b0;
      while (awaited_elements.size() != 0) @(posedge clock);
   endtask

   task automatic write_limits(int rows, int columns);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= ssmt_pkg::CSR_ROW_LIMIT;
      csr_wdata <= LIM_W'(rows);
      @(negedge clock);
      csr_index <= ssmt_pkg::CSR_COLUMN_LIMIT;
      csr_wdata <= LIM_W'(columns);
      @(negedge clock);
      csr_write <= 1'b0;
      row_bound = LIM_W'(rows);
      column_bound = LIM_W'(columns);
   endtask

   // response checker
   always @(posedge clock) begin : check_responses
      ssmt_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (awaited_elements.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: value %h status %0d count %0d",
                        rsp_data.element_value, rsp_data.status, rsp_data.nonzero_count);
         end else begin
            want = awaited_elements.pop_front();
            if (rsp_data.element_value !== want.element_value ||
                rsp_data.status !== want.status ||
                rsp_data.nonzero_count !== want.nonzero_count) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $write("response mismatch: expected value %h status %0d count %0d, ",
                         want.element_value, want.status, want.nonzero_count);
                  $display("got value %h status %0d count %0d",
                           rsp_data.element_value, rsp_data.status, rsp_data.nonzero_count);
               end
            end
         end
      end
   end

   initial begin : run_stimulus
      int p;
      int n;
      ssmt_pkg::rsp_type none;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = ssmt_pkg::CSR_ROW_LIMIT;
      csr_wdata = '0;
      mismatch_count = 0;
      stored_total = 0;
      row_bound = ssmt_pkg::LIMIT_RESET;
      column_bound = ssmt_pkg::LIMIT_RESET;
      pool_row = 0;
      pool_column = 0;
      none = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed requests with the last row and column just out of range
      write_limits(1023, 1023);
      add_probe(ssmt_pkg::ACT_READ,     0,    0, 0,     1, 0,     ssmt_pkg::ST_OK,    0);
      add_probe(ssmt_pkg::ACT_WRITE,    0,    0, 0,     1, 0,     ssmt_pkg::ST_OK,    0);
      add_probe(ssmt_pkg::ACT_ACCUM,    5,    5, 0,     1, 0,     ssmt_pkg::ST_OK,    0);
      add_probe(ssmt_pkg::ACT_WRITE, 1023,    0, 1,     1, 0,     ssmt_pkg::ST_RANGE, 0);
      add_probe(ssmt_pkg::ACT_READ,     0, 1023, 0,     1, 0,     ssmt_pkg::ST_RANGE, 0);
      add_probe(ssmt_pkg::ACT_ACCUM, 1023, 1023, Q_MAX, 1, 0,     ssmt_pkg::ST_RANGE, 0);
      add_probe(ssmt_pkg::ACT_WRITE,    0,    0, Q_MAX, 1, Q_MAX, ssmt_pkg::ST_OK,    1);
      add_probe(ssmt_pkg::ACT_WRITE,    0,    0, Q_ONE, 1, Q_ONE, ssmt_pkg::ST_OK,    1);
      add_probe(ssmt_pkg::ACT_WRITE, 1022, 1022, Q_MIN, 1, Q_MIN, ssmt_pkg::ST_OK,    2);
      add_probe(ssmt_pkg::ACT_ACCUM, 1022, 1022, -1,    1, Q_MIN, ssmt_pkg::ST_SAT,   2);
      add_probe(ssmt_pkg::ACT_ACCUM,    0,    0, Q_MAX, 1, Q_MAX, ssmt_pkg::ST_SAT,   2);
      add_probe(ssmt_pkg::ACT_ACCUM,    0,    0, Q_MIN + 1, 1, 0, ssmt_pkg::ST_OK,    1);
      add_probe(ssmt_pkg::ACT_WRITE,    3,    4, -Q_ONE, 0, 0, ssmt_pkg::ST_OK, 0);
      add_probe(ssmt_pkg::ACT_WRITE,    3,    2, 32'sh0000_8000, 0, 0, ssmt_pkg::ST_OK, 0);
      add_probe(ssmt_pkg::ACT_ACCUM,    3,    9, 32'sh1234_5678, 0, 0, ssmt_pkg::ST_OK, 0);
      add_probe(ssmt_pkg::ACT_READ,     3,    4, 32'sh5555_5555, 0, 0, ssmt_pkg::ST_OK, 0);
      add_probe(ACT_SPARE,              3,    2, 32'shAAAA_AAAA, 0, 0, ssmt_pkg::ST_OK, 0);
      add_probe(ssmt_pkg::ACT_WRITE,    3,    4, 0,     0, 0, ssmt_pkg::ST_OK, 0);
      add_probe(ssmt_pkg::ACT_READ,     3,    4, 0,     0, 0, ssmt_pkg::ST_OK, 0);
      add_probe(ssmt_pkg::ACT_ACCUM,    3,    9, -32'sh1234_5678, 0, 0, ssmt_pkg::ST_OK, 0);
      add_probe(ssmt_pkg::ACT_WRITE, 1022, 1022, 0,     0, 0, ssmt_pkg::ST_OK, 0);
      add_probe(ssmt_pkg::ACT_WRITE,    0,    0, -1,    0, 0, ssmt_pkg::ST_OK, 0);
      add_probe(ssmt_pkg::ACT_READ,  1022, 1022, 0,     0, 0, ssmt_pkg::ST_OK, 0);
      foreach (directed_rows[i])
         issue_request(directed_rows[i].request, directed_rows[i].typed,
                       directed_rows[i].response);
      drain_responses();

      // random phases, each with its own limits and sender idling
      for (p = 0; p < PHASES; p++) begin
         write_limits(phase_rows[p], phase_columns[p]);
         pool_row = (phase_rows[p] > 9) ? $urandom_range(0, phase_rows[p] - 9) : 0;
         pool_column = (phase_columns[p] > 8) ? $urandom_range(0, phase_columns[p] - 8) : 0;
         for (n = 0; n < phase_items[p]; n++) begin
            sender_gap(phase_idle[p]);
            issue_request(random_request(), 1'b0, none);
         end
         drain_responses();
      end

      // let any stray response show up, then judge
      repeat (SETTLE_CYCLES) @(posedge clock);
      mismatch_count += awaited_elements.size();
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
